@@ rtl/serial_controller_register_port_macros.svh @@
// Assertion macros used by the serial controller register port top level.
`ifndef SERIAL_CONTROLLER_REGISTER_PORT_MACROS_SVH
`define SERIAL_CONTROLLER_REGISTER_PORT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define SCRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("serial controller register port assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("serial controller register port assertion failed");

`else

`define SCRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SCRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/scrp_pkg.sv @@
// Package with the word types, decode struct and constants of the register port.
`default_nettype none

package scrp_pkg;

    localparam int NUM_CH      = 2;
    localparam int REGS_PER_CH = 16;
    localparam int NUM_REGS    = NUM_CH * REGS_PER_CH;

    localparam logic       KIND_WRITE     = 1'b1;
    localparam logic [2:0] LEGAL_SIZE     = 3'd1;
    localparam logic [7:0] MAX_OFFSET     = 8'd6;
    localparam logic [2:0] POINT_HIGH_CMD = 3'b001;

    localparam logic [3:0] REG_STATUS0   = 4'd0;
    localparam logic [3:0] REG_STATUS1   = 4'd1;
    localparam logic [3:0] REG_VECTOR    = 4'd2;
    localparam logic [3:0] REG_RESET_CMD = 4'd9;
    localparam logic [3:0] REG_BAUD_LO   = 4'd12;
    localparam logic [3:0] REG_BAUD_HI   = 4'd13;

    localparam logic [7:0] STATUS0_VALUE = 8'h2c;
    localparam logic [7:0] STATUS1_VALUE = 8'h01;

    localparam int RESET_B_BIT = 6;
    localparam int RESET_A_BIT = 7;

    typedef struct packed {
        logic       kind;
        logic [7:0] offset;
        logic [2:0] access_size;
        logic [7:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic       accepted;
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } t_out_word;

    // Decoded access; every strobe below already includes the legality check.
    typedef struct packed {
        logic legal;
        logic ch;
        logic ctrl_wr;
        logic ctrl_rd;
        logic data_wr;
    } t_dec;

endpackage

`default_nettype wire

@@ rtl/serial_controller_register_port.sv @@
// Top level of the two-channel serial controller register port.
`default_nettype none
`include "serial_controller_register_port_macros.svh"

// The block takes one bus access word per cycle while not stalled and returns
// exactly one result word for each, in order. An access word is captured in
// an input register at the edge that accepts it. There it is decoded, and in
// the cycle it advances, the channel's register pointer and write register
// file are read and updated and the result is formed and loaded into the
// output register. The sustained rate is one word per cycle while the output
// is not stalled. Only byte accesses at offsets 0 (channel B control),
// 2 (channel A control), 4 (channel B data) and 6 (channel A data) are taken;
// any other access returns a result word with every field zero and leaves the
// state alone. A control write with a zero pointer loads the pointer (the
// point-high command adds 8); with a nonzero pointer it stores the byte and
// clears the pointer, and a store to register 9 can clear either channel.
// Control reads return fixed status for registers 0 and 1, the stored byte
// for registers 2, 12 and 13, and zero otherwise. A data write reports the
// byte on tx_valid and tx_byte. The output register may be held by stall
// while the input register still takes a new word, and input stall rises
// only when both registers are full and the output is stalled.
module serial_controller_register_port (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  scrp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output scrp_pkg::t_out_word o_out_word
);

    logic                r_in_valid;
    scrp_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    scrp_pkg::t_out_word r_out_word;
    scrp_pkg::t_out_word n_out_word;
    scrp_pkg::t_dec      dec;
    logic [7:0]          rd_byte;
    logic                advance;
    logic                in_acc;

    // The held word moves on when the output register is empty or draining.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    scrp_decode u_decode (
        .i_word (r_in_word),
        .o_dec  (dec)
    );

    // State changes at most once per word, and only in the cycle the word advances.
    scrp_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_dec       (dec),
        .i_data      (r_in_word.write_data),
        .o_read_data (rd_byte)
    );

    always_comb begin
        n_out_word.accepted  = dec.legal;
        n_out_word.read_data = rd_byte;
        n_out_word.tx_valid  = dec.data_wr;
        n_out_word.tx_byte   = dec.data_wr ? r_in_word.write_data : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_acc || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A refused access carries an all-zero result.
    `SCRP_ASSERT_NOW(a_refused_zero, i_clk, i_rst_n,
        r_out_valid && !r_out_word.accepted,
        (r_out_word.read_data == 8'h00) && !r_out_word.tx_valid &&
        (r_out_word.tx_byte == 8'h00))
    // A transmit result never carries read data.
    `SCRP_ASSERT_NOW(a_tx_no_read, i_clk, i_rst_n,
        r_out_valid && r_out_word.tx_valid, r_out_word.read_data == 8'h00)
    // A word held behind a stalled output is not dropped.
    `SCRP_ASSERT_NEXT(a_hold_in, i_clk, i_rst_n,
        r_in_valid && r_out_valid && i_out_stall, r_in_valid && $stable(r_in_word))
    // An accepted word always lands in the input register.
    `SCRP_ASSERT_NEXT(a_capture, i_clk, i_rst_n, in_acc, r_in_valid)
    // Advancing a word always fills the output register.
    `SCRP_ASSERT_NEXT(a_advance, i_clk, i_rst_n, advance, r_out_valid)

endmodule

`default_nettype wire

@@ rtl/scrp_decode.sv @@
// Address and size decode of one bus access word.
`default_nettype none

module scrp_decode (
    input  scrp_pkg::t_in_word i_word,
    output scrp_pkg::t_dec     o_dec
);

    logic legal;
    logic is_wr;

    assign legal = (i_word.access_size == scrp_pkg::LEGAL_SIZE) &&
                   (i_word.offset <= scrp_pkg::MAX_OFFSET) && !i_word.offset[0];
    assign is_wr = (i_word.kind == scrp_pkg::KIND_WRITE);

    // Offset bit 1 selects channel A, offset bit 2 selects the data port.
    always_comb begin
        o_dec.legal   = legal;
        o_dec.ch      = i_word.offset[1];
        o_dec.ctrl_wr = legal && !i_word.offset[2] && is_wr;
        o_dec.ctrl_rd = legal && !i_word.offset[2] && !is_wr;
        o_dec.data_wr = legal && i_word.offset[2] && is_wr;
    end

endmodule

`default_nettype wire

@@ rtl/scrp_regfile.sv @@
// Register pointers and write register file of both channels.
`default_nettype none

module scrp_regfile (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  scrp_pkg::t_dec i_dec,
    input  logic [7:0]     i_data,
    output logic [7:0]     o_read_data
);

    logic [3:0] r_ptr  [scrp_pkg::NUM_CH];
    logic [3:0] n_ptr  [scrp_pkg::NUM_CH];
    logic [7:0] r_file [scrp_pkg::NUM_REGS];
    logic [7:0] n_file [scrp_pkg::NUM_REGS];
    logic [3:0] cur_ptr;
    logic [4:0] cur_idx;
    logic [7:0] rd_byte;

    assign cur_ptr = r_ptr[i_dec.ch];
    assign cur_idx = {i_dec.ch, cur_ptr};

    always_comb begin
        case (cur_ptr)
            scrp_pkg::REG_STATUS0: rd_byte = scrp_pkg::STATUS0_VALUE;
            scrp_pkg::REG_STATUS1: rd_byte = scrp_pkg::STATUS1_VALUE;
            scrp_pkg::REG_VECTOR,
            scrp_pkg::REG_BAUD_LO,
            scrp_pkg::REG_BAUD_HI: rd_byte = r_file[cur_idx];
            default:               rd_byte = 8'h00;
        endcase
    end

    assign o_read_data = i_dec.ctrl_rd ? rd_byte : 8'h00;

    always_comb begin
        n_ptr  = r_ptr;
        n_file = r_file;
        if (i_en && i_dec.ctrl_wr) begin
            if (cur_ptr == 4'd0) begin
                n_ptr[i_dec.ch] = {(i_data[5:3] == scrp_pkg::POINT_HIGH_CMD), i_data[2:0]};
            end else begin
                n_ptr[i_dec.ch] = 4'd0;
                n_file[cur_idx] = i_data;
                // The channel reset command wins over the byte just stored.
                if (cur_ptr == scrp_pkg::REG_RESET_CMD) begin
                    if (i_data[scrp_pkg::RESET_B_BIT]) begin
                        n_ptr[0] = 4'd0;
                        for (int k = 0; k < scrp_pkg::REGS_PER_CH; k++) begin
                            n_file[5'(k)] = 8'h00;
                        end
                    end
                    if (i_data[scrp_pkg::RESET_A_BIT]) begin
                        n_ptr[1] = 4'd0;
                        for (int k = 0; k < scrp_pkg::REGS_PER_CH; k++) begin
                            n_file[5'(scrp_pkg::REGS_PER_CH + k)] = 8'h00;
                        end
                    end
                end
            end
        end else if (i_en && i_dec.ctrl_rd) begin
            n_ptr[i_dec.ch] = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '{default: '0};
            r_file <= '{default: '0};
        end else begin
            r_ptr  <= n_ptr;
            r_file <= n_file;
        end
    end

endmodule

`default_nettype wire
